// File: hdl/p2pf_pkg.sv
`default_nettype none

package p2pf_pkg;

  // item opcodes
  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_FADE_IN   = 2'd1,
    OP_FADE_STOP = 2'd2,
    OP_CANCEL    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ENV_IDLE = 2'd0,
    ENV_RISE = 2'd1,
    ENV_FALL = 2'd2
  } fade_mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_VOLUME = 2'd0,
    CFG_STEREO = 2'd1
  } cfg_index_e;

  localparam int LevelW    = 11;
  localparam int GainW     = 9;
  localparam int VolW      = 7;
  localparam int SampleW   = 16;
  localparam int PackedW   = 27;

  localparam logic [LevelW-1:0] LevelMax = 11'd2047;
  localparam logic [LevelW-1:0] LevelMid = 11'd1023;
  localparam logic [GainW-1:0]  GainUnity = 9'd256;
  localparam logic [VolW-1:0]   VolReset  = 7'd100;

  // floor(2^19 / 100): quotient estimate low by at most one
  localparam logic [12:0] Recip100 = 13'd5242;
  localparam int          RecipShift = 19;

  // pipeline depth of a lane, in register stages
  localparam int LaneLat = 5;

  // per-word fade results handed from the fade control to lanes and merge
  typedef struct packed {
    logic [GainW-1:0] gain;
    logic             stop;
    logic             busy;
  } fade_info_t;

endpackage

`default_nettype wire

// File: hdl/p2pf_lane.sv
`default_nettype none

module p2pf_lane
  import p2pf_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic [SampleW-1:0]        sample_i,
  input  wire logic                      present_i,
  input  wire logic [VolW-1:0]           volume_i,
  input  wire logic [GainW-1:0]          gain_i,
  output logic      [LevelW-1:0]         level_o
);

  logic [LevelW-1:0]  raw_lvl;
  logic [17:0]        prod1_d, prod1_q;
  logic [30:0]        est_full;
  logic [11:0]        est_q;
  logic [17:0]        prod2_q;
  logic [17:0]        est_x100;
  logic [17:0]        rem;
  logic [11:0]        quot;
  logic [LevelW-1:0]  lvl_d, lvl_q;
  logic signed [11:0] diff;
  logic signed [19:0] diff_x, gain_x, fprod_d, fprod_q;
  logic signed [11:0] shifted;
  logic signed [12:0] sum;
  logic [LevelW-1:0]  out_d, out_q;

  // offset to unsigned, keep top 11 bits
  assign raw_lvl = {~sample_i[SampleW-1], sample_i[SampleW-2:5]};
  assign prod1_d = {7'b0, raw_lvl} * {11'b0, volume_i};

  assign est_full = {13'b0, prod1_q} * {18'b0, Recip100};

  // one correction step on the reciprocal estimate
  assign est_x100 = {6'b0, est_q} * 18'd100;
  assign rem      = prod2_q - est_x100;
  assign quot     = (rem >= 18'd100) ? est_q + 12'd1 : est_q;

  always_comb begin
    if (!present_i) begin
      lvl_d = LevelMid;
    end else if (quot > {1'b0, LevelMax}) begin
      lvl_d = LevelMax;
    end else begin
      lvl_d = quot[LevelW-1:0];
    end
  end

  // fade around the midpoint
  assign diff    = $signed({1'b0, lvl_q}) - $signed({1'b0, LevelMid});
  assign diff_x  = 20'(diff);
  assign gain_x  = 20'($signed({1'b0, gain_i}));
  assign fprod_d = diff_x * gain_x;

  assign shifted = fprod_q[19:8];
  assign sum     = {shifted[11], shifted} + $signed({2'b0, LevelMid});

  always_comb begin
    if (sum < 13'sd0) begin
      out_d = '0;
    end else if (sum > $signed({2'b0, LevelMax})) begin
      out_d = LevelMax;
    end else begin
      out_d = sum[LevelW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= prod1_d;
    est_q   <= est_full[RecipShift +: 12];
    prod2_q <= prod1_q;
    lvl_q   <= lvl_d;
    fprod_q <= fprod_d;
    out_q   <= out_d;
  end

  assign level_o = out_q;

endmodule

`default_nettype wire

// File: hdl/p2pf_fade_ctrl.sv
`default_nettype none

module p2pf_fade_ctrl
  import p2pf_pkg::*;
#(
  parameter int FADE_LENGTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire opcode_e     opcode_i,
  output fade_info_t       info_o
);

  localparam int PosW = $clog2(FADE_LENGTH + 1);

  fade_mode_e         mode_q, mode_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               stop_q, stop_d;
  fade_info_t         info_q, info_d;
  logic [PosW-1:0]    gain_idx;
  logic [PosW:0]      pos_nx;
  logic               fading;
  logic [GainW-1:0]   gain_tab [FADE_LENGTH+1];

  // envelope table, pos*256/FADE_LENGTH
  for (genvar g = 0; g <= FADE_LENGTH; g++) begin : g_tab
    assign gain_tab[g] = GainW'(g * 256 / FADE_LENGTH);
  end

  assign fading   = (mode_q == ENV_RISE) || (mode_q == ENV_FALL);
  assign gain_idx = (mode_q == ENV_RISE) ? pos_q : PosW'(FADE_LENGTH) - pos_q;
  assign pos_nx   = {1'b0, pos_q} + 1'b1;

  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    stop_d = stop_q;
    info_d = info_q;
    if (accept_i) begin
      case (opcode_i)
        OP_FADE_IN: begin
          mode_d = ENV_RISE;
          pos_d  = '0;
          stop_d = 1'b0;
        end
        OP_FADE_STOP: begin
          mode_d = ENV_FALL;
          pos_d  = '0;
          stop_d = 1'b1;
        end
        OP_CANCEL: begin
          mode_d = ENV_IDLE;
          stop_d = 1'b0;
        end
        OP_SAMPLE: begin
          info_d.gain = GainUnity;
          info_d.stop = 1'b0;
          info_d.busy = 1'b0;
          if (fading) begin
            info_d.gain = gain_tab[gain_idx];
            info_d.busy = 1'b1;
            pos_d       = pos_nx[PosW-1:0];
            if (pos_nx >= (PosW+1)'(FADE_LENGTH)) begin
              if (mode_q == ENV_FALL && stop_q) begin
                info_d.stop = 1'b1;
                stop_d      = 1'b0;
              end
              mode_d = ENV_IDLE;
            end
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ENV_IDLE;
      pos_q  <= '0;
      stop_q <= 1'b0;
      info_q <= '{gain: GainUnity, stop: 1'b0, busy: 1'b0};
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      stop_q <= stop_d;
      info_q <= info_d;
    end
  end

  assign info_o = info_q;

endmodule

`default_nettype wire

// File: hdl/p2pf_merge.sv
`default_nettype none

module p2pf_merge
  import p2pf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire logic [LevelW-1:0] left_i,
  input  wire logic [LevelW-1:0] right_i,
  input  wire fade_info_t        info_i,
  input  wire logic              out_stall_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  output logic [LevelW-1:0]      left_level_o,
  output logic [LevelW-1:0]      right_level_o,
  output logic [PackedW-1:0]     packed_word_o,
  output logic                   stop_pulse_o,
  output logic                   fade_busy_o
);

  logic                valid_q;
  logic [LevelW-1:0]   left_q, right_q;
  logic [PackedW-1:0]  packed_q;
  logic                stop_q, busy_q;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      left_q   <= left_i;
      right_q  <= right_i;
      packed_q <= {right_i, 5'b0, left_i};
      stop_q   <= info_i.stop;
      busy_q   <= info_i.busy;
    end
  end

  assign out_valid_o   = valid_q;
  assign left_level_o  = left_q;
  assign right_level_o = right_q;
  assign packed_word_o = packed_q;
  assign stop_pulse_o  = stop_q;
  assign fade_busy_o   = busy_q;

endmodule

`default_nettype wire

// File: hdl/pcm_to_pwm_level_with_fade_core.sv
// PCM to PWM level converter, left and right lanes side by side.
// A sample word is registered at the input, passes the 5-stage lane pipeline and is
// loaded into the merge register once that is free; no new sample word is taken until
// then. Control words change only the fade state and give no result word.
// Reset (async, active low): volume 100, stereo, no fade, output empty.
`default_nettype none

module pcm_to_pwm_level_with_fade_core
  import p2pf_pkg::*;
#(
  parameter int FADE_LENGTH = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [1:0]                cfg_index_i,
  input  wire logic [VolW-1:0]           cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                opcode_i,
  input  wire logic                      sample_present_i,
  input  wire logic signed [SampleW-1:0] left_sample_i,
  input  wire logic signed [SampleW-1:0] right_sample_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [LevelW-1:0]              left_level_o,
  output logic [LevelW-1:0]              right_level_o,
  output logic [PackedW-1:0]             packed_word_o,
  output logic                           stop_pulse_o,
  output logic                           fade_busy_o
);

  localparam logic [2:0] CntDone = 3'(LaneLat + 1);

  logic [VolW-1:0]    volume_q;
  logic               stereo_q;
  logic [2:0]         cnt_q, cnt_d;
  logic [SampleW-1:0] left_q, right_q;
  logic               present_q;
  logic               accept, accept_smp, load, free;
  opcode_e            op;
  fade_info_t         info;
  logic [LevelW-1:0]  left_lvl, right_lvl;

  assign op          = opcode_e'(opcode_i);
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (cnt_q != 3'd0);
  assign accept      = in_valid_i && !in_stall_o;
  assign accept_smp  = accept && (op == OP_SAMPLE);
  assign load        = (cnt_q == CntDone) && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= VolReset;
      stereo_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_VOLUME: volume_q <= cfg_data_i;
        CFG_STEREO: stereo_q <= cfg_data_i[0];
        default:    volume_q <= volume_q;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept_smp) begin
      cnt_d = 3'd1;
    end else if (load) begin
      cnt_d = 3'd0;
    end else if (cnt_q != 3'd0 && cnt_q != CntDone) begin
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // mono: right lane takes the left word
  always_ff @(posedge clk_i) begin
    if (accept_smp) begin
      left_q    <= left_sample_i;
      right_q   <= stereo_q ? right_sample_i : left_sample_i;
      present_q <= sample_present_i;
    end
  end

  p2pf_fade_ctrl #(
    .FADE_LENGTH(FADE_LENGTH)
  ) u_fade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .opcode_i(op),
    .info_o  (info)
  );

  p2pf_lane u_lane_l (
    .clk_i    (clk_i),
    .sample_i (left_q),
    .present_i(present_q),
    .volume_i (volume_q),
    .gain_i   (info.gain),
    .level_o  (left_lvl)
  );

  p2pf_lane u_lane_r (
    .clk_i    (clk_i),
    .sample_i (right_q),
    .present_i(present_q),
    .volume_i (volume_q),
    .gain_i   (info.gain),
    .level_o  (right_lvl)
  );

  p2pf_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .left_i       (left_lvl),
    .right_i      (right_lvl),
    .info_i       (info),
    .out_stall_i  (out_stall_i),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .left_level_o (left_level_o),
    .right_level_o(right_level_o),
    .packed_word_o(packed_word_o),
    .stop_pulse_o (stop_pulse_o),
    .fade_busy_o  (fade_busy_o)
  );

endmodule

`default_nettype wire

// File: test/pcm_level_checker.sv
`default_nettype none

module pcm_level_checker
  import p2pf_pkg::*;
#(
  parameter int FADE_LENGTH = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  input  wire logic                      cfg_ready_i,
  input  wire logic [1:0]                cfg_index_i,
  input  wire logic [VolW-1:0]           cfg_data_i,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_stall_i,
  input  wire logic [1:0]                opcode_i,
  input  wire logic                      sample_present_i,
  input  wire logic signed [SampleW-1:0] left_sample_i,
  input  wire logic signed [SampleW-1:0] right_sample_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_stall_i,
  input  wire logic [LevelW-1:0]         left_level_i,
  input  wire logic [LevelW-1:0]         right_level_i,
  input  wire logic [PackedW-1:0]        packed_word_i,
  input  wire logic                      stop_pulse_i,
  input  wire logic                      fade_busy_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LevelW-1:0]  left;
    logic [LevelW-1:0]  right;
    logic [PackedW-1:0] word;
    logic               stop;
    logic               busy;
  } level_word_t;

  logic [VolW-1:0] volume;
  logic            stereo;
  fade_mode_e      fade_mode;
  int unsigned     fade_pos;
  logic            stop_armed;
  int              errors;
  int              compared;
  level_word_t     expected_levels[$];

  function automatic logic [LevelW-1:0] scale_level(logic signed [SampleW-1:0] s);
    int lv;
    lv = (int'(s) + 32768) >>> 5;
    lv = lv * int'(volume) / 100;
    if (lv > int'(LevelMax)) begin
      lv = int'(LevelMax);
    end
    return lv[LevelW-1:0];
  endfunction

  // envelope scales the distance from midpoint; >>> gives floor rounding
  function automatic logic [LevelW-1:0] apply_fade(logic [LevelW-1:0] lv, int gain);
    int r;
    r = int'(LevelMid) + (((int'(lv) - int'(LevelMid)) * gain) >>> 8);
    if (r < 0) begin
      r = 0;
    end
    if (r > int'(LevelMax)) begin
      r = int'(LevelMax);
    end
    return r[LevelW-1:0];
  endfunction

  function automatic level_word_t predict_levels(logic present,
                                                 logic signed [SampleW-1:0] l,
                                                 logic signed [SampleW-1:0] r);
    level_word_t w;
    int unsigned pos;
    int          gain;
    w.stop = 1'b0;
    w.busy = 1'b0;
    if (present) begin
      w.left  = scale_level(l);
      w.right = scale_level(stereo ? r : l);
    end else begin
      w.left  = LevelMid;
      w.right = LevelMid;
    end
    if (fade_mode == ENV_RISE || fade_mode == ENV_FALL) begin
      pos = (fade_pos > FADE_LENGTH) ? FADE_LENGTH : fade_pos;
      if (fade_mode == ENV_RISE) begin
        gain = int'(pos * int'(GainUnity) / FADE_LENGTH);
      end else begin
        gain = int'((FADE_LENGTH - pos) * int'(GainUnity) / FADE_LENGTH);
      end
      w.left   = apply_fade(w.left, gain);
      w.right  = apply_fade(w.right, gain);
      w.busy   = 1'b1;
      fade_pos = pos + 1;
      if (fade_pos >= FADE_LENGTH) begin
        if (fade_mode == ENV_FALL && stop_armed) begin
          w.stop     = 1'b1;
          stop_armed = 1'b0;
        end
        fade_mode = ENV_IDLE;
      end
    end
    w.word = {w.right, {(PackedW-2*LevelW){1'b0}}, w.left};
    return w;
  endfunction

  function automatic int field_differs(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    level_word_t want;
    if (!rst_ni) begin
      volume     = VolReset;
      stereo     = 1'b1;
      fade_mode  = ENV_IDLE;
      fade_pos   = 0;
      stop_armed = 1'b0;
      errors     = 0;
      compared   = 0;
      expected_levels.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_VOLUME: volume = cfg_data_i;
          CFG_STEREO: stereo = cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_levels.size() == 0) begin
          $error("result word with nothing expected: left %0d right %0d",
                 left_level_i, right_level_i);
          errors++;
        end else begin
          want = expected_levels.pop_front();
          compared++;
          if (field_differs("left_level", want.left, left_level_i) +
              field_differs("right_level", want.right, right_level_i) +
              field_differs("packed_word", want.word, packed_word_i) +
              field_differs("stop_pulse", want.stop, stop_pulse_i) +
              field_differs("fade_busy", want.busy, fade_busy_i) != 0) begin
            errors++;
          end
        end
      end

      // control words change the envelope only, no result
      if (in_valid_i && !in_stall_i) begin
        case (opcode_e'(opcode_i))
          OP_SAMPLE: begin
            expected_levels.push_back(predict_levels(sample_present_i, left_sample_i,
                                                     right_sample_i));
          end
          OP_FADE_IN: begin
            fade_mode  = ENV_RISE;
            fade_pos   = 0;
            stop_armed = 1'b0;
          end
          OP_FADE_STOP: begin
            fade_mode  = ENV_FALL;
            fade_pos   = 0;
            stop_armed = 1'b1;
          end
          default: begin
            fade_mode  = ENV_IDLE;
            stop_armed = 1'b0;
          end
        endcase
      end

      fail_count_o <= errors;
      pending_o    <= expected_levels.size();
      checked_o    <= compared;
    end
  end

endmodule

`default_nettype wire

// File: test/pcm_to_pwm_level_with_fade_core_tb.sv
`default_nettype none

module pcm_to_pwm_level_with_fade_core_tb;
  import p2pf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FadeLen   = 64;
  localparam int HoldCycles = 300;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = CFG_VOLUME;
  logic [VolW-1:0]           cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                opcode = OP_SAMPLE;
  logic                      present = 1'b0;
  logic signed [SampleW-1:0] left = '0;
  logic signed [SampleW-1:0] right = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [LevelW-1:0]         left_level;
  logic [LevelW-1:0]         right_level;
  logic [PackedW-1:0]        packed_word;
  logic                      stop_pulse;
  logic                      fade_busy;
  int                        fail_count;
  int                        pending;
  int                        checked;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int words_sent = 0;
  int slots_sent = 0;
  int settings = 0;

  pcm_to_pwm_level_with_fade_core #(
    .FADE_LENGTH(FadeLen)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .sample_present_i(present),
    .left_sample_i   (left),
    .right_sample_i  (right),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .left_level_o    (left_level),
    .right_level_o   (right_level),
    .packed_word_o   (packed_word),
    .stop_pulse_o    (stop_pulse),
    .fade_busy_o     (fade_busy)
  );

  pcm_level_checker #(
    .FADE_LENGTH(FadeLen)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .opcode_i        (opcode),
    .sample_present_i(present),
    .left_sample_i   (left),
    .right_sample_i  (right),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .left_level_i    (left_level),
    .right_level_i   (right_level),
    .packed_word_i   (packed_word),
    .stop_pulse_i    (stop_pulse),
    .fade_busy_i     (fade_busy),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 18);
      end
    end
  end

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(opcode_e op, logic pres, logic signed [SampleW-1:0] l,
                           logic signed [SampleW-1:0] r);
    if (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    present  <= pres;
    left     <= l;
    right    <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (op == OP_SAMPLE) begin
      slots_sent++;
    end
  endtask

  task automatic send_random_slot();
    send_word(OP_SAMPLE, $urandom_range(99) < 85, rand_sample(), rand_sample());
  endtask

  task automatic send_control(opcode_e op);
    send_word(op, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
  endtask

  // wait for every expected word, then keep the input idle before returning
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LaneLat + 8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [VolW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_levels(logic [VolW-1:0] vol, logic [VolW-1:0] stereo_data);
    write_reg(CFG_VOLUME, vol);
    write_reg(CFG_STEREO, stereo_data);
    settings++;
  endtask

  initial begin
    int      phase;
    int      start;
    int      n;
    int      cut;
    opcode_e op;
    logic [VolW-1:0] vol;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, sample extremes and each control word
    send_word(OP_SAMPLE, 1'b1, 16'sh8000, 16'sh7FFF);
    send_word(OP_SAMPLE, 1'b1, 16'sh7FFF, 16'sh8000);
    send_word(OP_SAMPLE, 1'b1, 16'sh0000, -16'sd1);
    send_word(OP_SAMPLE, 1'b0, 16'sh7FFF, 16'sh8000);
    send_control(OP_FADE_IN);
    send_word(OP_SAMPLE, 1'b1, 16'sh7FFF, 16'sh8000);
    send_word(OP_SAMPLE, 1'b1, 16'sh8000, 16'sh7FFF);
    send_word(OP_SAMPLE, 1'b0, 16'sh1234, -16'sd77);
    send_control(OP_FADE_IN);
    send_control(OP_CANCEL);
    send_word(OP_SAMPLE, 1'b1, 16'sh4000, -16'sh4000);
    send_control(OP_FADE_STOP);
    send_word(OP_SAMPLE, 1'b1, 16'sh8000, 16'sh7FFF);
    send_word(OP_SAMPLE, 1'b1, -16'sd31, 16'sd33);
    send_control(OP_CANCEL);
    send_word(OP_SAMPLE, 1'b1, 16'sh7FFF, 16'sh8000);
    drain();
    // gain above unity must clamp
    set_levels(7'd127, 7'd1);
    send_word(OP_SAMPLE, 1'b1, 16'sh7FFF, 16'sh4000);
    drain();
    set_levels(7'd0, 7'd1);
    send_word(OP_SAMPLE, 1'b1, 16'sh7FFF, 16'sh8000);
    send_word(OP_SAMPLE, 1'b0, 16'sh7FFF, 16'sh8000);
    drain();
    set_levels(7'd100, 7'b1111110);
    send_word(OP_SAMPLE, 1'b1, 16'sd100, -16'sd5000);
    send_word(OP_SAMPLE, 1'b1, 16'sh8000, 16'sh7FFF);
    drain();

    // random: each phase under one register setting, mostly fade runs of varying length
    start = words_sent;
    phase = 0;
    while (words_sent - start < 1100) begin
      case (phase)
        0: set_levels(7'd100, {6'($urandom), 1'b1});
        1: set_levels(7'd0, {6'($urandom), 1'b0});
        2: set_levels(7'd127, {6'($urandom), 1'b1});
        3: set_levels(7'd1, {6'($urandom), 1'b0});
        default: begin
          if ($urandom_range(99) < 20) begin
            vol = 7'($urandom_range(101, 127));
          end else begin
            vol = 7'($urandom_range(0, 100));
          end
          set_levels(vol, 7'($urandom_range(127)));
        end
      endcase
      quiet    = (phase == 6);
      hold_req = (phase == 4);
      n = words_sent;
      while (words_sent - n < 120) begin
        if ($urandom_range(99) < 65) begin
          op = $urandom_range(1) ? OP_FADE_STOP : OP_FADE_IN;
          send_control(op);
          cut = $urandom_range(40, 80);
          // now and then break the fade off, or restart it, part way through
          if ($urandom_range(99) < 15) begin
            cut = -$urandom_range(1, cut - 1);
          end
          for (int i = 0; i < ((cut < 0) ? 80 : cut); i++) begin
            if (cut < 0 && i == -cut) begin
              send_control($urandom_range(1) ? OP_CANCEL : op);
            end
            send_random_slot();
          end
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_word(opcode_e'($urandom_range(3)), 1'($urandom_range(1)),
                      rand_sample(), rand_sample());
          end
        end
      end
      drain();
      quiet = 1'b0;
      phase++;
    end

    $display("Sent %0d input words (%0d sample slots, %0d results checked) over %0d settings,",
             words_sent, slots_sent, checked, settings);
    $display("including full fades, stop fades, restarts and a long output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
